FILE: design/rpt_pkg.sv
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types and constants for the IPv6 route prefix table: operation
// codes, sequencer states, stored route word and control bundles.
// ----------------------------------------------------------------------------
package rpt_pkg;

    localparam int unsigned PREFIX_W = 128;
    localparam int unsigned LEN_W    = 8;
    localparam int unsigned IFACE_W  = 7;
    localparam int unsigned SLOT_IN_W = 3;

    // Longest legal prefix; longer lengths are stored but never match.
    localparam logic [LEN_W-1:0] MAX_PREFIX = 8'd128;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_RSVD   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RANK,
        ST_SWEEP,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [63:0]        prefix_high;
        logic [63:0]        prefix_low;
        logic [LEN_W-1:0]   length;
        logic [IFACE_W-1:0] iface;
    } t_route;

    typedef struct packed {
        logic route_we;
        logic rank_we;
        logic re;
    } t_mem_ctl;

    typedef struct packed {
        logic clear;
        logic s1_vld;
    } t_match_ctl;

    typedef struct packed {
        logic               found;
        logic [IFACE_W-1:0] iface;
        logic [LEN_W-1:0]   length;
    } t_lookup_res;

    typedef struct packed {
        logic               status;
        logic               found;
        logic [IFACE_W-1:0] iface;
        logic [LEN_W-1:0]   length;
    } t_result;

endpackage

FILE: design/rpt_route_mem.sv
// ----------------------------------------------------------------------------
// rpt_route_mem
// Route storage: one memory of route words and one memory of age ranks,
// each with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rpt_route_mem #(
    parameter int ROUTE_SLOTS = 8,
    localparam int SLOT_W = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1
) (
    input  logic                            i_clk,
    input  rpt_pkg::t_mem_ctl               i_ctl,
    input  logic [SLOT_W-1:0]               i_route_waddr,
    input  rpt_pkg::t_route                 i_route_wdata,
    input  logic [SLOT_W-1:0]               i_rank_waddr,
    input  logic [SLOT_W-1:0]               i_rank_wdata,
    input  logic [SLOT_W-1:0]               i_raddr,
    output rpt_pkg::t_route                 o_route_rdata,
    output logic [SLOT_W-1:0]               o_rank_rdata
);

    rpt_pkg::t_route   route_mem [ROUTE_SLOTS];
    logic [SLOT_W-1:0] rank_mem  [ROUTE_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.route_we) begin
            route_mem[i_route_waddr] <= i_route_wdata;
        end
        if (i_ctl.re) begin
            o_route_rdata <= route_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rank_we) begin
            rank_mem[i_rank_waddr] <= i_rank_wdata;
        end
        if (i_ctl.re) begin
            o_rank_rdata <= rank_mem[i_raddr];
        end
    end

endmodule

FILE: design/rpt_match.sv
// ----------------------------------------------------------------------------
// rpt_match
// Two-stage prefix matcher: compares one stored route per cycle against the
// destination, then keeps the longest match, oldest route first on a tie.
// ----------------------------------------------------------------------------
module rpt_match #(
    parameter int ROUTE_SLOTS = 8,
    localparam int SLOT_W = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rpt_pkg::t_match_ctl             i_ctl,
    input  rpt_pkg::t_route                 i_entry,
    input  logic [SLOT_W-1:0]               i_rank,
    input  logic [rpt_pkg::PREFIX_W-1:0]    i_dest,
    output logic                            o_busy,
    output rpt_pkg::t_lookup_res            o_res
);

    logic [rpt_pkg::PREFIX_W-1:0] mask;
    logic [rpt_pkg::PREFIX_W-1:0] diff;
    logic                         hit;

    logic                          r_s2_vld;
    logic [rpt_pkg::LEN_W-1:0]     r_s2_len;
    logic [SLOT_W-1:0]             r_s2_rank;
    logic [rpt_pkg::IFACE_W-1:0]   r_s2_iface;

    logic                          r_have;
    logic [rpt_pkg::LEN_W-1:0]     r_best_len;
    logic [SLOT_W-1:0]             r_best_rank;
    logic [rpt_pkg::IFACE_W-1:0]   r_best_iface;
    logic                          better;

    // Leading length bits must agree; a length past 128 never matches.
    always_comb begin
        mask = ~({rpt_pkg::PREFIX_W{1'b1}} >> i_entry.length);
        diff = {i_entry.prefix_high, i_entry.prefix_low} ^ i_dest;
        hit  = (i_entry.length <= rpt_pkg::MAX_PREFIX) && ((diff & mask) == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= i_ctl.s1_vld && hit;
        end
        r_s2_len   <= i_entry.length;
        r_s2_rank  <= i_rank;
        r_s2_iface <= i_entry.iface;
    end

    assign better = !r_have || (r_s2_len > r_best_len) ||
                    ((r_s2_len == r_best_len) && (r_s2_rank < r_best_rank));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctl.clear) begin
            r_have <= 1'b0;
        end else if (r_s2_vld && better) begin
            r_have <= 1'b1;
        end
        if (r_s2_vld && better && !i_ctl.clear) begin
            r_best_len   <= r_s2_len;
            r_best_rank  <= r_s2_rank;
            r_best_iface <= r_s2_iface;
        end
    end

    assign o_busy       = r_s2_vld;
    assign o_res.found  = r_have;
    assign o_res.iface  = r_have ? r_best_iface : '0;
    assign o_res.length = r_have ? r_best_len : '0;

endmodule

FILE: design/rpt_ctrl.sv
// ----------------------------------------------------------------------------
// rpt_ctrl
// Operation sequencer: holds the valid bits and route count, writes routes,
// sweeps age ranks on remove and walks the memory for a lookup.
// ----------------------------------------------------------------------------
module rpt_ctrl #(
    parameter int ROUTE_SLOTS = 8,
    localparam int SLOT_W = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_func,
    input  logic [rpt_pkg::SLOT_IN_W-1:0]      i_route_slot,
    input  logic [63:0]                        i_prefix_high,
    input  logic [63:0]                        i_prefix_low,
    input  logic [rpt_pkg::LEN_W-1:0]          i_prefix_length,
    input  logic [rpt_pkg::IFACE_W-1:0]        i_route_interface,
    input  logic [63:0]                        i_dest_high,
    input  logic [63:0]                        i_dest_low,
    input  logic                               i_out_free,
    output logic                               o_done,
    output rpt_pkg::t_result                   o_result,
    output rpt_pkg::t_mem_ctl                  o_mem_ctl,
    output logic [SLOT_W-1:0]                  o_route_waddr,
    output rpt_pkg::t_route                    o_route_wdata,
    output logic [SLOT_W-1:0]                  o_rank_waddr,
    output logic [SLOT_W-1:0]                  o_rank_wdata,
    output logic [SLOT_W-1:0]                  o_raddr,
    input  logic [SLOT_W-1:0]                  i_rank_rdata,
    output rpt_pkg::t_match_ctl                o_match_ctl,
    output logic [rpt_pkg::PREFIX_W-1:0]       o_dest,
    input  logic                               i_match_busy,
    input  rpt_pkg::t_lookup_res               i_lookup
);

    localparam int CNT_W  = $clog2(ROUTE_SLOTS + 1);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(ROUTE_SLOTS);

    rpt_pkg::t_state  r_state, n_state;
    rpt_pkg::t_func   r_func;
    logic [rpt_pkg::SLOT_IN_W-1:0] r_slot;
    rpt_pkg::t_route  r_route;
    logic [rpt_pkg::PREFIX_W-1:0]  r_dest;

    logic [ROUTE_SLOTS-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic                   r_sw_vld, n_sw_vld;
    logic [SLOT_W-1:0]      r_sw_addr, n_sw_addr;
    logic [SLOT_W-1:0]      r_rm_rank, n_rm_rank;
    logic                   r_status, n_status;

    logic                   in_acc;
    logic                   slot_ok;
    logic [SLOT_W-1:0]      slot_addr;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign slot_ok   = (32'(r_slot) < ROUTE_SLOTS);
    assign slot_addr = SLOT_W'(r_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rpt_pkg::ST_IDLE;
            r_valid  <= '0;
            r_count  <= '0;
            r_sw_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_count  <= n_count;
            r_sw_vld <= n_sw_vld;
        end
        r_idx     <= n_idx;
        r_sw_addr <= n_sw_addr;
        r_rm_rank <= n_rm_rank;
        r_status  <= n_status;
        if (in_acc) begin
            r_func              <= rpt_pkg::t_func'(i_func);
            r_slot              <= i_route_slot;
            r_route.prefix_high <= i_prefix_high;
            r_route.prefix_low  <= i_prefix_low;
            r_route.length      <= i_prefix_length;
            r_route.iface       <= i_route_interface;
            r_dest              <= {i_dest_high, i_dest_low};
        end
    end

    always_comb begin
        n_state       = r_state;
        n_valid       = r_valid;
        n_count       = r_count;
        n_idx         = r_idx;
        n_sw_vld      = 1'b0;
        n_sw_addr     = r_sw_addr;
        n_rm_rank     = r_rm_rank;
        n_status      = r_status;
        o_mem_ctl     = '0;
        o_route_waddr = slot_addr;
        o_rank_waddr  = slot_addr;
        o_rank_wdata  = r_count[SLOT_W-1:0];
        o_raddr       = slot_addr;
        o_match_ctl   = '0;
        o_done        = 1'b0;
        o_in_stall    = (r_state != rpt_pkg::ST_IDLE);

        o_match_ctl.s1_vld = (r_state == rpt_pkg::ST_SCAN) && r_sw_vld &&
                             r_valid[r_sw_addr];

        unique case (r_state)
            rpt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = rpt_pkg::ST_EXEC;
                end
            end
            rpt_pkg::ST_EXEC: begin
                n_status = 1'b0;
                n_idx    = '0;
                unique case (r_func)
                    rpt_pkg::FUNC_ADD: begin
                        if (slot_ok) begin
                            if (r_valid[slot_addr]) begin
                                n_status = 1'b1;
                            end else begin
                                o_mem_ctl.route_we = 1'b1;
                                o_mem_ctl.rank_we  = 1'b1;
                                n_valid[slot_addr] = 1'b1;
                                n_count            = r_count + 1'b1;
                            end
                        end
                        n_state = rpt_pkg::ST_DONE;
                    end
                    rpt_pkg::FUNC_REMOVE: begin
                        if (slot_ok && r_valid[slot_addr]) begin
                            o_mem_ctl.re = 1'b1;
                            n_state      = rpt_pkg::ST_RANK;
                        end else begin
                            n_state = rpt_pkg::ST_DONE;
                        end
                    end
                    rpt_pkg::FUNC_LOOKUP: begin
                        o_match_ctl.clear = 1'b1;
                        n_state           = rpt_pkg::ST_SCAN;
                    end
                    default: begin
                        n_state = rpt_pkg::ST_DONE;
                    end
                endcase
            end
            rpt_pkg::ST_RANK: begin
                // Rank of the removed route is back; free the slot.
                n_rm_rank          = i_rank_rdata;
                n_valid[slot_addr] = 1'b0;
                n_count            = r_count - 1'b1;
                n_state            = rpt_pkg::ST_SWEEP;
            end
            rpt_pkg::ST_SWEEP, rpt_pkg::ST_SCAN: begin
                if (r_idx != SCAN_END) begin
                    o_mem_ctl.re = 1'b1;
                    o_raddr      = r_idx[SLOT_W-1:0];
                    n_sw_vld     = 1'b1;
                    n_sw_addr    = r_idx[SLOT_W-1:0];
                    n_idx        = r_idx + 1'b1;
                end
                // Move every younger route one rank down.
                if ((r_state == rpt_pkg::ST_SWEEP) && r_sw_vld && r_valid[r_sw_addr] &&
                    (i_rank_rdata > r_rm_rank)) begin
                    o_mem_ctl.rank_we = 1'b1;
                    o_rank_waddr      = r_sw_addr;
                    o_rank_wdata      = i_rank_rdata - 1'b1;
                end
                if ((r_idx == SCAN_END) && !r_sw_vld && !i_match_busy) begin
                    n_state = rpt_pkg::ST_DONE;
                end
            end
            rpt_pkg::ST_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = rpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rpt_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_route_wdata = r_route;
    assign o_dest        = r_dest;

    always_comb begin
        o_result.status = r_status;
        if (r_func == rpt_pkg::FUNC_LOOKUP) begin
            o_result.found  = i_lookup.found;
            o_result.iface  = i_lookup.iface;
            o_result.length = i_lookup.length;
        end else begin
            o_result.found  = 1'b0;
            o_result.iface  = '0;
            o_result.length = '0;
        end
    end

    a_count_tracks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) == $countones(r_valid))
        else $error("route count out of step with valid bits");

    a_add_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_ctl.route_we |-> !r_valid[o_route_waddr])
        else $error("route written over a slot in use");

    a_done_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> i_out_free)
        else $error("result issued while output register is full");

    a_remove_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpt_pkg::ST_RANK) |=> !r_valid[slot_addr])
        else $error("removed slot still marked valid");

endmodule

FILE: design/ipv6_route_prefix_table.sv
// ----------------------------------------------------------------------------
// ipv6_route_prefix_table
// Small IPv6 route table with add, remove and longest-prefix-match lookup.
// Timing: add, remove of a free slot and unused codes finish without walking
//   the route memory; lookup and remove of a used slot walk it one slot per
//   cycle through its single read port.
// Throughput: one transaction in flight; the next is accepted the cycle after
//   the previous result moves into the output register.
// Reset: synchronous, active low; clears all routes, the sequencer and the
//   output valid.
// ----------------------------------------------------------------------------
module ipv6_route_prefix_table #(
    parameter int ROUTE_SLOTS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_func,
    input  logic [rpt_pkg::SLOT_IN_W-1:0]      i_route_slot,
    input  logic [63:0]                        i_prefix_high,
    input  logic [63:0]                        i_prefix_low,
    input  logic [rpt_pkg::LEN_W-1:0]          i_prefix_length,
    input  logic [rpt_pkg::IFACE_W-1:0]        i_route_interface,
    input  logic [63:0]                        i_dest_high,
    input  logic [63:0]                        i_dest_low,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_status,
    output logic                               o_found,
    output logic [rpt_pkg::IFACE_W-1:0]        o_out_interface,
    output logic [rpt_pkg::LEN_W-1:0]          o_match_length
);

    localparam int SLOT_W = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;

    rpt_pkg::t_mem_ctl     mem_ctl;
    logic [SLOT_W-1:0]     route_waddr;
    rpt_pkg::t_route       route_wdata;
    logic [SLOT_W-1:0]     rank_waddr;
    logic [SLOT_W-1:0]     rank_wdata;
    logic [SLOT_W-1:0]     raddr;
    rpt_pkg::t_route       route_rdata;
    logic [SLOT_W-1:0]     rank_rdata;
    rpt_pkg::t_match_ctl   match_ctl;
    logic [rpt_pkg::PREFIX_W-1:0] dest;
    logic                  match_busy;
    rpt_pkg::t_lookup_res  lookup;
    logic                  done;
    rpt_pkg::t_result      result;
    logic                  out_free;

    logic                  r_out_vld;
    rpt_pkg::t_result      r_out;

    rpt_ctrl #(
        .ROUTE_SLOTS(ROUTE_SLOTS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_route_slot     (i_route_slot),
        .i_prefix_high    (i_prefix_high),
        .i_prefix_low     (i_prefix_low),
        .i_prefix_length  (i_prefix_length),
        .i_route_interface(i_route_interface),
        .i_dest_high      (i_dest_high),
        .i_dest_low       (i_dest_low),
        .i_out_free       (out_free),
        .o_done           (done),
        .o_result         (result),
        .o_mem_ctl        (mem_ctl),
        .o_route_waddr    (route_waddr),
        .o_route_wdata    (route_wdata),
        .o_rank_waddr     (rank_waddr),
        .o_rank_wdata     (rank_wdata),
        .o_raddr          (raddr),
        .i_rank_rdata     (rank_rdata),
        .o_match_ctl      (match_ctl),
        .o_dest           (dest),
        .i_match_busy     (match_busy),
        .i_lookup         (lookup)
    );

    rpt_route_mem #(
        .ROUTE_SLOTS(ROUTE_SLOTS)
    ) u_mem (
        .i_clk        (i_clk),
        .i_ctl        (mem_ctl),
        .i_route_waddr(route_waddr),
        .i_route_wdata(route_wdata),
        .i_rank_waddr (rank_waddr),
        .i_rank_wdata (rank_wdata),
        .i_raddr      (raddr),
        .o_route_rdata(route_rdata),
        .o_rank_rdata (rank_rdata)
    );

    rpt_match #(
        .ROUTE_SLOTS(ROUTE_SLOTS)
    ) u_match (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (match_ctl),
        .i_entry(route_rdata),
        .i_rank (rank_rdata),
        .i_dest (dest),
        .o_busy (match_busy),
        .o_res  (lookup)
    );

    // Output register: load a finished result, drop it once taken.
    assign out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (done) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
        if (done) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_out.status;
    assign o_found         = r_out.found;
    assign o_out_interface = r_out.iface;
    assign o_match_length  = r_out.length;

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IPv6 route prefix table. A command queue is
// filled with a directed opening and then random add, remove, lookup and unused
// code commands built around a few shared prefixes, so that nested and tied
// routes occur often. Every accepted command is applied to a local shadow of
// the route table, and each returned reply is checked field by field, in
// order, against the shadow's answer.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          SLOTS       = 8;
    localparam int          RANDOM_CMDS = 724;
    localparam int          HOLD_AT     = 260;
    localparam int          HOLD_CYCLES = 500;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          PRINT_LIMIT = 50;
    localparam logic [127:0] ALL_ONES   = '1;

    typedef struct packed {
        rpt_pkg::t_func                         func;
        logic [rpt_pkg::SLOT_IN_W-1:0]          slot;
        logic [rpt_pkg::PREFIX_W-1:0]           prefix;
        logic [rpt_pkg::LEN_W-1:0]              length;
        logic [rpt_pkg::IFACE_W-1:0]            iface;
        logic [rpt_pkg::PREFIX_W-1:0]           dest;
        logic                                   drain_first;
    } t_route_cmd;

    logic                          i_clk             = 1'b0;
    logic                          i_rst_n           = 1'b0;
    logic                          i_in_valid        = 1'b0;
    logic [1:0]                    i_func            = '0;
    logic [rpt_pkg::SLOT_IN_W-1:0] i_route_slot      = '0;
    logic [63:0]                   i_prefix_high     = '0;
    logic [63:0]                   i_prefix_low      = '0;
    logic [rpt_pkg::LEN_W-1:0]     i_prefix_length   = '0;
    logic [rpt_pkg::IFACE_W-1:0]   i_route_interface = '0;
    logic [63:0]                   i_dest_high       = '0;
    logic [63:0]                   i_dest_low        = '0;
    logic                          i_out_stall       = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic                          o_status;
    logic                          o_found;
    logic [rpt_pkg::IFACE_W-1:0]   o_out_interface;
    logic [rpt_pkg::LEN_W-1:0]     o_match_length;

    // shadow of the route table
    logic                         tbl_valid [SLOTS];
    logic [rpt_pkg::PREFIX_W-1:0] tbl_prefix[SLOTS];
    logic [rpt_pkg::LEN_W-1:0]    tbl_len   [SLOTS];
    logic [rpt_pkg::IFACE_W-1:0]  tbl_iface [SLOTS];
    int unsigned                  tbl_rank  [SLOTS];

    t_route_cmd        cmd_q[$];
    rpt_pkg::t_result  reply_q[$];
    t_route_cmd        cur_cmd;
    int unsigned sent_cnt    = 0;
    int unsigned reply_cnt   = 0;
    int unsigned tx_gap      = 0;
    int unsigned rx_wait     = 0;
    int unsigned hold_left   = 0;
    logic        hold_used   = 1'b0;
    int unsigned cycle_cnt   = 0;
    int unsigned err_cnt     = 0;
    int unsigned add_cnt     = 0;
    int unsigned remove_cnt  = 0;
    int unsigned lookup_cnt  = 0;
    int unsigned other_cnt   = 0;
    int unsigned hit_cnt     = 0;
    logic [rpt_pkg::PREFIX_W-1:0] anchor[4];

    ipv6_route_prefix_table #(
        .ROUTE_SLOTS(SLOTS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_route_slot     (i_route_slot),
        .i_prefix_high    (i_prefix_high),
        .i_prefix_low     (i_prefix_low),
        .i_prefix_length  (i_prefix_length),
        .i_route_interface(i_route_interface),
        .i_dest_high      (i_dest_high),
        .i_dest_low       (i_dest_low),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_found          (o_found),
        .o_out_interface  (o_out_interface),
        .o_match_length   (o_match_length)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Apply one command to the shadow table and return the reply it must give.
    function automatic rpt_pkg::t_result apply_route_cmd(t_route_cmd c);
        rpt_pkg::t_result             r;
        int                           i;
        int unsigned                  n_live;
        int unsigned                  best_rank;
        logic [rpt_pkg::PREFIX_W-1:0] mask;
        r = '0;
        best_rank = 0;
        case (c.func)
            rpt_pkg::FUNC_ADD: begin
                add_cnt++;
                if (tbl_valid[c.slot]) begin
                    r.status = 1'b1;
                end else begin
                    n_live = 0;
                    for (i = 0; i < SLOTS; i++)
                        if (tbl_valid[i]) n_live++;
                    tbl_valid[c.slot]  = 1'b1;
                    tbl_prefix[c.slot] = c.prefix;
                    tbl_len[c.slot]    = c.length;
                    tbl_iface[c.slot]  = c.iface;
                    tbl_rank[c.slot]   = n_live;
                end
            end
            rpt_pkg::FUNC_REMOVE: begin
                remove_cnt++;
                if (tbl_valid[c.slot]) begin
                    tbl_valid[c.slot] = 1'b0;
                    // close the gap in the age order
                    for (i = 0; i < SLOTS; i++)
                        if (tbl_valid[i] && tbl_rank[i] > tbl_rank[c.slot]) tbl_rank[i]--;
                end
            end
            rpt_pkg::FUNC_LOOKUP: begin
                lookup_cnt++;
                for (i = 0; i < SLOTS; i++) begin
                    if (tbl_valid[i] && tbl_len[i] <= rpt_pkg::MAX_PREFIX) begin
                        mask = ~(ALL_ONES >> tbl_len[i]);
                        if (((tbl_prefix[i] ^ c.dest) & mask) == '0 &&
                            (!r.found || tbl_len[i] > r.length ||
                             (tbl_len[i] == r.length && tbl_rank[i] < best_rank))) begin
                            r.found   = 1'b1;
                            r.length  = tbl_len[i];
                            r.iface   = tbl_iface[i];
                            best_rank = tbl_rank[i];
                        end
                    end
                end
                if (r.found) hit_cnt++;
            end
            default: begin
                other_cnt++;
            end
        endcase
        return r;
    endfunction

    function automatic logic [rpt_pkg::PREFIX_W-1:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic void queue_cmd(rpt_pkg::t_func f, int unsigned slot,
                                      logic [rpt_pkg::PREFIX_W-1:0] pfx,
                                      int unsigned len, int unsigned ifc,
                                      logic [rpt_pkg::PREFIX_W-1:0] dst);
        t_route_cmd c;
        c.func        = f;
        c.slot        = slot[rpt_pkg::SLOT_IN_W-1:0];
        c.prefix      = pfx;
        c.length      = len[rpt_pkg::LEN_W-1:0];
        c.iface       = ifc[rpt_pkg::IFACE_W-1:0];
        c.dest        = dst;
        c.drain_first = 1'b0;
        cmd_q.push_back(c);
    endfunction

    // Keep a shared prefix up to one random cut, OR in random bits past a second, independent cut.
    function automatic logic [rpt_pkg::PREFIX_W-1:0] near_anchor();
        return anchor[$urandom_range(0, 3)] & ~(ALL_ONES >> $urandom_range(0, 128)) |
               rand128() & (ALL_ONES >> $urandom_range(0, 128));
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        err_cnt++;
        if (err_cnt <= PRINT_LIMIT)
            $display("mismatch on reply %0d: %s is %0d, expected %0d",
                     reply_cnt, field, got, want);
    endtask

    // Sender: present queued commands, with random gaps and drain points.
    always @(posedge i_clk) begin : drive_cmds
        logic        fire;
        int unsigned gap_v;
        t_route_cmd  nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_gap     <= 0;
        end else begin
            fire  = i_in_valid && !o_in_stall;
            gap_v = tx_gap;
            if (fire) begin
                reply_q.push_back(apply_route_cmd(cur_cmd));
                sent_cnt <= sent_cnt + 1;
                gap_v = ((sent_cnt / 64) % 3 == 0) ? 0 : $urandom_range(0, 11);
            end
            if (!i_in_valid || fire) begin
                if (gap_v != 0) begin
                    i_in_valid <= 1'b0;
                    tx_gap     <= gap_v - 1;
                end else if (cmd_q.size() != 0 &&
                             (!cmd_q[0].drain_first || (!fire && sent_cnt == reply_cnt))) begin
                    nxt     = cmd_q.pop_front();
                    cur_cmd = nxt;
                    i_func            <= nxt.func;
                    i_route_slot      <= nxt.slot;
                    i_prefix_high     <= nxt.prefix[127:64];
                    i_prefix_low      <= nxt.prefix[63:0];
                    i_prefix_length   <= nxt.length;
                    i_route_interface <= nxt.iface;
                    i_dest_high       <= nxt.dest[127:64];
                    i_dest_low        <= nxt.dest[63:0];
                    i_in_valid        <= 1'b1;
                    tx_gap            <= 0;
                end else begin
                    i_in_valid <= 1'b0;
                    tx_gap     <= 0;
                end
            end
        end
    end

    // Receiver: check each reply and draw the stall before the next one.
    always @(posedge i_clk) begin : check_replies
        int unsigned      wait_v;
        rpt_pkg::t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_wait     <= 0;
        end else begin
            wait_v = (rx_wait != 0) ? rx_wait - 1 : 0;
            if (o_out_valid && !i_out_stall) begin
                reply_cnt <= reply_cnt + 1;
                if (reply_q.size() == 0) begin
                    report_mismatch("reply with nothing pending, status", o_status, 0);
                end else begin
                    want = reply_q.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                    if (o_found !== want.found)
                        report_mismatch("found", o_found, want.found);
                    if (o_out_interface !== want.iface)
                        report_mismatch("out_interface", o_out_interface, want.iface);
                    if (o_match_length !== want.length)
                        report_mismatch("match_length", o_match_length, want.length);
                end
                wait_v = ((reply_cnt / 50) % 3 == 1) ? 0 : $urandom_range(0, 11);
            end
            rx_wait     <= wait_v;
            i_out_stall <= (wait_v != 0) || (hold_left != 0);
        end
    end

    // Long receiver hold-off: the sender keeps offering, so the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (!hold_used && reply_cnt == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d replies seen",
                     cycle_cnt, reply_cnt, sent_cnt);
            $display("FAIL ipv6_route_prefix_table");
            $finish;
        end
    end

    initial begin : stimulus
        int                           n;
        int                           k;
        int unsigned                  pick;
        int unsigned                  len;
        rpt_pkg::t_func               f;
        logic [rpt_pkg::PREFIX_W-1:0] pfx;
        logic [rpt_pkg::PREFIX_W-1:0] dst;
        logic [rpt_pkg::PREFIX_W-1:0] doc_a;
        logic [rpt_pkg::PREFIX_W-1:0] doc_b;
        logic [rpt_pkg::PREFIX_W-1:0] doc_dst;

        doc_a   = {64'h2001_0db8_0000_0000, 64'h0};
        doc_b   = {64'h2001_0db8_ffff_0000, 64'h1234};
        doc_dst = {64'h2001_0db8_0001_0002, 64'h99};
        for (k = 0; k < SLOTS; k++) tbl_valid[k] = 1'b0;

        // directed opening
        queue_cmd(rpt_pkg::FUNC_LOOKUP, 0, '0, 0, 0, ALL_ONES);     // empty table
        queue_cmd(rpt_pkg::FUNC_RSVD, 7, ALL_ONES, 255, 127, ALL_ONES);
        queue_cmd(rpt_pkg::FUNC_ADD, 0, '0, 0, 5, '0);              // default route
        queue_cmd(rpt_pkg::FUNC_LOOKUP, 0, '0, 0, 0, ALL_ONES);
        queue_cmd(rpt_pkg::FUNC_ADD, 0, ALL_ONES, 128, 9, '0);      // slot in use
        queue_cmd(rpt_pkg::FUNC_ADD, 7, ALL_ONES, 128, 127, '0);
        queue_cmd(rpt_pkg::FUNC_LOOKUP, 0, '0, 0, 0, ALL_ONES);
        queue_cmd(rpt_pkg::FUNC_LOOKUP, 0, '0, 0, 0, ALL_ONES ^ 128'd1);
        queue_cmd(rpt_pkg::FUNC_ADD, 3, ALL_ONES, 129, 9, '0);      // never matches
        queue_cmd(rpt_pkg::FUNC_ADD, 4, ALL_ONES, 255, 10, '0);
        queue_cmd(rpt_pkg::FUNC_LOOKUP, 0, '0, 0, 0, ALL_ONES);
        queue_cmd(rpt_pkg::FUNC_REMOVE, 7, '0, 0, 0, '0);
        queue_cmd(rpt_pkg::FUNC_LOOKUP, 0, '0, 0, 0, ALL_ONES);
        queue_cmd(rpt_pkg::FUNC_REMOVE, 5, '0, 0, 0, '0);           // free slot
        queue_cmd(rpt_pkg::FUNC_ADD, 1, doc_a, 32, 1, '0);
        queue_cmd(rpt_pkg::FUNC_ADD, 2, doc_b, 32, 2, '0);          // tie, younger
        queue_cmd(rpt_pkg::FUNC_LOOKUP, 0, '0, 0, 0, doc_dst);
        queue_cmd(rpt_pkg::FUNC_REMOVE, 1, '0, 0, 0, '0);
        queue_cmd(rpt_pkg::FUNC_LOOKUP, 0, '0, 0, 0, doc_dst);
        queue_cmd(rpt_pkg::FUNC_ADD, 1, doc_a, 32, 3, '0);
        queue_cmd(rpt_pkg::FUNC_LOOKUP, 0, '0, 0, 0, doc_dst);
        queue_cmd(rpt_pkg::FUNC_ADD, 5, {1'b1, 127'd0}, 1, 0, '0);
        queue_cmd(rpt_pkg::FUNC_LOOKUP, 0, '0, 0, 0, {1'b1, 127'h5a5a});
        queue_cmd(rpt_pkg::FUNC_LOOKUP, 0, '0, 0, 0, '0);
        queue_cmd(rpt_pkg::FUNC_ADD, 6, '0, 128, 64, '0);
        queue_cmd(rpt_pkg::FUNC_LOOKUP, 0, '0, 0, 0, '0);

        for (n = 0; n < RANDOM_CMDS; n++) begin
            if (n % 150 == 0)
                for (k = 0; k < 4; k++) anchor[k] = rand128();
            pick = $urandom_range(0, 99);
            if (pick < 30)      f = rpt_pkg::FUNC_ADD;
            else if (pick < 48) f = rpt_pkg::FUNC_REMOVE;
            else if (pick < 95) f = rpt_pkg::FUNC_LOOKUP;
            else                f = rpt_pkg::FUNC_RSVD;
            pick = $urandom_range(0, 99);
            if (pick < 80)      len = $urandom_range(0, 128);
            else if (pick < 90) len = ($urandom_range(0, 1) != 0) ? 128 : 0;
            else                len = $urandom_range(129, 255);
            pfx = ($urandom_range(0, 9) == 0) ? rand128() : near_anchor();
            dst = ($urandom_range(0, 9) == 0) ? rand128() : near_anchor();
            queue_cmd(f, $urandom_range(0, 7), pfx, len, $urandom_range(0, 127), dst);
            if (n % 200 == 199) cmd_q[$].drain_first = 1'b1;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || i_in_valid || sent_cnt != reply_cnt) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("covered %0d commands: %0d add, %0d remove, %0d lookup, %0d unused code",
                 sent_cnt, add_cnt, remove_cnt, lookup_cnt, other_cnt);
        $display("%0d lookups hit a route, %0d mismatches", hit_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("PASS ipv6_route_prefix_table");
        end else begin
            $display("FAIL ipv6_route_prefix_table");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/rpt_pkg.sv
design/rpt_route_mem.sv
design/rpt_match.sv
design/rpt_ctrl.sv
design/ipv6_route_prefix_table.sv
bench/tb_top.sv
